@@ design/assert_macros.svh @@
// Assertion helpers clocked on clk_i and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define PPD_NEVER(lbl, cond, msg) \
  `PPD_ASSERT(lbl, !(cond), msg)

`endif

@@ design/ppd_pkg.sv @@
package ppd_pkg;

  localparam int MaxLengthBytes = 4;
  localparam int LenCntW        = 2;
  localparam int ByteW          = 8;
  localparam int RemLenW        = 28;
  localparam int TopicLenW      = 16;
  localparam int KindW          = 3;
  localparam int MinRemLen      = 2;

  typedef enum logic [KindW-1:0] {
    KIND_HEADER  = 3'd0,
    KIND_LENGTH  = 3'd1,
    KIND_TLEN    = 3'd2,
    KIND_TOPIC   = 3'd3,
    KIND_PAYLOAD = 3'd4,
    KIND_BAD     = 3'd5
  } kind_e;

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_LENGTH  = 6'b000010,
    PH_TLEN_HI = 6'b000100,
    PH_TLEN_LO = 6'b001000,
    PH_TOPIC   = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0]     byte_value;
    kind_e                part_kind;
    logic                 packet_end;
    logic [RemLenW-1:0]   frame_length;
    logic [TopicLenW-1:0] topic_length;
  } result_t;

endpackage

@@ design/ppd_parse.sv @@
module ppd_parse (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [ppd_pkg::ByteW-1:0]   byte_i,
  output ppd_pkg::result_t            result_o
);

  ppd_pkg::phase_e                     phase_q, phase_d;
  logic [ppd_pkg::LenCntW-1:0]         cnt_q, cnt_d;
  logic [ppd_pkg::RemLenW-1:0]         dec_q, dec_d;
  logic [ppd_pkg::RemLenW-1:0]         left_q, left_d;
  logic [ppd_pkg::TopicLenW-1:0]       tlen_q, tlen_d;
  logic [ppd_pkg::TopicLenW-1:0]       tleft_q, tleft_d;

  logic [ppd_pkg::RemLenW-1:0]         left_dec;
  logic [ppd_pkg::TopicLenW-1:0]       tleft_dec;
  logic [ppd_pkg::TopicLenW-1:0]       tlen_full;
  logic [ppd_pkg::RemLenW-1:0]         len_sum;
  logic                                cnt_last;
  ppd_pkg::kind_e                      kind;
  logic                                pkt_end;
  logic [ppd_pkg::TopicLenW-1:0]       tlen_out;

  assign left_dec  = left_q - ppd_pkg::RemLenW'(1);
  assign tleft_dec = tleft_q - ppd_pkg::TopicLenW'(1);
  assign tlen_full = {tlen_q[ppd_pkg::TopicLenW-1:ppd_pkg::ByteW], byte_i};
  assign len_sum   = dec_q + (ppd_pkg::RemLenW'(byte_i[6:0]) << (5'(cnt_q) * 5'd7));
  assign cnt_last  = (3'(cnt_q) + 3'd1) >= 3'(ppd_pkg::MaxLengthBytes);

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    dec_d    = dec_q;
    left_d   = left_q;
    tlen_d   = tlen_q;
    tleft_d  = tleft_q;
    kind     = ppd_pkg::KIND_HEADER;
    pkt_end  = 1'b0;
    tlen_out = '0;
    unique case (phase_q)
      ppd_pkg::PH_HEADER: begin
        cnt_d   = '0;
        dec_d   = '0;
        left_d  = '0;
        tlen_d  = '0;
        tleft_d = '0;
        phase_d = ppd_pkg::PH_LENGTH;
      end
      ppd_pkg::PH_LENGTH: begin
        kind  = ppd_pkg::KIND_LENGTH;
        dec_d = len_sum;
        if (byte_i[7]) begin
          if (cnt_last) begin
            kind    = ppd_pkg::KIND_BAD;
            pkt_end = 1'b1;
            phase_d = ppd_pkg::PH_HEADER;
          end else begin
            cnt_d = cnt_q + ppd_pkg::LenCntW'(1);
          end
        end else if (len_sum < ppd_pkg::RemLenW'(ppd_pkg::MinRemLen)) begin
          kind    = ppd_pkg::KIND_BAD;
          pkt_end = 1'b1;
          phase_d = ppd_pkg::PH_HEADER;
        end else begin
          left_d  = len_sum;
          phase_d = ppd_pkg::PH_TLEN_HI;
        end
      end
      ppd_pkg::PH_TLEN_HI: begin
        kind    = ppd_pkg::KIND_TLEN;
        tlen_d  = {byte_i, ppd_pkg::ByteW'(0)};
        left_d  = left_dec;
        phase_d = ppd_pkg::PH_TLEN_LO;
      end
      ppd_pkg::PH_TLEN_LO: begin
        kind     = ppd_pkg::KIND_TLEN;
        tlen_d   = tlen_full;
        tlen_out = tlen_full;
        left_d   = left_dec;
        if (ppd_pkg::RemLenW'(tlen_full) > left_dec) begin
          kind    = ppd_pkg::KIND_BAD;
          pkt_end = 1'b1;
          phase_d = ppd_pkg::PH_HEADER;
        end else begin
          tleft_d = tlen_full;
          if (left_dec == '0) begin
            pkt_end = 1'b1;
            phase_d = ppd_pkg::PH_HEADER;
          end else if (tlen_full != '0) begin
            phase_d = ppd_pkg::PH_TOPIC;
          end else begin
            phase_d = ppd_pkg::PH_PAYLOAD;
          end
        end
      end
      ppd_pkg::PH_TOPIC: begin
        kind     = ppd_pkg::KIND_TOPIC;
        tlen_out = tlen_q;
        tleft_d  = tleft_dec;
        left_d   = left_dec;
        if (left_dec == '0) begin
          pkt_end = 1'b1;
          phase_d = ppd_pkg::PH_HEADER;
        end else if (tleft_dec == '0) begin
          phase_d = ppd_pkg::PH_PAYLOAD;
        end
      end
      ppd_pkg::PH_PAYLOAD: begin
        kind     = ppd_pkg::KIND_PAYLOAD;
        tlen_out = tlen_q;
        left_d   = left_dec;
        if (left_dec == '0) begin
          pkt_end = 1'b1;
          phase_d = ppd_pkg::PH_HEADER;
        end
      end
      default: begin
        phase_d = ppd_pkg::PH_HEADER;
      end
    endcase
  end

  always_comb begin
    result_o.byte_value   = byte_i;
    result_o.part_kind    = kind;
    result_o.packet_end   = pkt_end;
    result_o.frame_length = (kind == ppd_pkg::KIND_HEADER) ? '0 : dec_d;
    result_o.topic_length = tlen_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ppd_pkg::PH_HEADER;
      cnt_q   <= '0;
      dec_q   <= '0;
      left_q  <= '0;
      tlen_q  <= '0;
      tleft_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      dec_q   <= dec_d;
      left_q  <= left_d;
      tlen_q  <= tlen_d;
      tleft_q <= tleft_d;
    end
  end

endmodule

@@ design/ppd_out_reg.sv @@
module ppd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ppd_pkg::result_t  result_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              stall_i,
  output ppd_pkg::result_t  result_o
);

  logic             valid_q;
  ppd_pkg::result_t result_q;

  assign ready_o  = !valid_q || !stall_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_i;
    end
  end

endmodule

@@ design/publish_packet_deframer_top.sv @@
// Path: a word accepted into the input register is parsed combinationally,
// registered in the result register and held there on the ports while stalled.
// Throughput: one word per cycle; the input register and the result register
// each advance whenever the stage after them is free.
// Reset: rst_ni clears the valid flags and returns the parser to awaiting a
// header word, with all decoded lengths at zero.
module publish_packet_deframer_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ppd_pkg::ByteW-1:0]            data_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ppd_pkg::ByteW-1:0]            byte_value_o,
  output logic [ppd_pkg::KindW-1:0]            part_kind_o,
  output logic                                 packet_end_o,
  output logic [ppd_pkg::RemLenW-1:0]          frame_length_o,
  output logic [ppd_pkg::TopicLenW-1:0]        topic_length_o
);

  logic                        in_valid_q;
  logic [ppd_pkg::ByteW-1:0]   in_byte_q;
  logic                        in_ready;
  logic                        out_ready;
  logic                        step;
  ppd_pkg::result_t            step_result;
  ppd_pkg::result_t            out_result;

  assign step       = in_valid_q && out_ready;
  assign in_ready   = !in_valid_q || out_ready;
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      in_byte_q <= data_byte_i;
    end
  end

  ppd_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (step_result)
  );

  ppd_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_q),
    .result_i (step_result),
    .ready_o  (out_ready),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .result_o (out_result)
  );

  assign byte_value_o   = out_result.byte_value;
  assign part_kind_o    = out_result.part_kind;
  assign packet_end_o   = out_result.packet_end;
  assign frame_length_o = out_result.frame_length;
  assign topic_length_o = out_result.topic_length;

endmodule

@@ design/ppd_checker.sv @@
`include "assert_macros.svh"

module ppd_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [ppd_pkg::ByteW-1:0]            byte_value_o,
  input logic [ppd_pkg::KindW-1:0]            part_kind_o,
  input logic                                 packet_end_o,
  input logic [ppd_pkg::RemLenW-1:0]          frame_length_o,
  input logic [ppd_pkg::TopicLenW-1:0]        topic_length_o
);

  `PPD_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_value_o) &&
      $stable(part_kind_o) && $stable(frame_length_o),
    "stalled result word changed")

  `PPD_ASSERT(a_bad_ends,
    out_valid_o && part_kind_o == ppd_pkg::KIND_BAD |-> packet_end_o,
    "malformed word without packet end")

  `PPD_NEVER(a_hdr_zero,
    out_valid_o && part_kind_o == ppd_pkg::KIND_HEADER &&
      (frame_length_o != '0 || topic_length_o != '0 || packet_end_o),
    "header word carries lengths or end")

  `PPD_ASSERT(a_end_kind,
    out_valid_o && packet_end_o |-> part_kind_o == ppd_pkg::KIND_TLEN ||
      part_kind_o == ppd_pkg::KIND_TOPIC || part_kind_o == ppd_pkg::KIND_PAYLOAD ||
      part_kind_o == ppd_pkg::KIND_BAD,
    "packet end on a header or length word")

endmodule

bind publish_packet_deframer_top ppd_checker u_ppd_checker (.*);
